/* rtl/block_csr_scatter_accumulate_macros.svh */
`ifndef BLOCK_CSR_SCATTER_ACCUMULATE_MACROS_SVH
`define BLOCK_CSR_SCATTER_ACCUMULATE_MACROS_SVH

// same-cycle implication, checked while out of reset
`define BCSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define BCSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bcsa_pkg.sv */
`timescale 1ns / 1ps

package bcsa_pkg;

    // default sizes
    localparam int MAX_NODES_DEF  = 4096;
    localparam int MAX_BLOCKS_DEF = 32768;
    localparam int DOFS_DEF       = 3;

    // field widths
    localparam int OP_W     = 3;
    localparam int COORD_W  = 13;
    localparam int ELEM_W   = 6;
    localparam int INDEX_W  = 19;
    localparam int PTR_W    = 16;
    localparam int VAL_W    = 64;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 13;
    localparam int COL_W    = 12;

    // command queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_ROW = 3'd0,
        OP_LOAD_COL = 3'd1,
        OP_CLEAR    = 3'd2,
        OP_MAT_ADD  = 3'd3,
        OP_VEC_ADD  = 3'd4,
        OP_RD_MAT   = 3'd5,
        OP_RD_VEC   = 3'd6,
        OP_UNUSED   = 3'd7
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_IGNORED   = 3'd1,
        ST_RANGE     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_BAD_INDEX = 3'd4
    } t_status;

    // classified transaction handed from front to back
    typedef struct packed {
        t_op                op;
        t_status            status;
        logic [COL_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [ELEM_W-1:0]  elem;
        logic [INDEX_W-1:0] index;
        logic [PTR_W-1:0]   pointer;
        logic [VAL_W-1:0]   value;
    } t_cmd;

    typedef struct packed {
        logic init_busy;
    } t_back_stat;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } t_fp_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] sum;
    } t_fp_rsp;

endpackage

/* rtl/bcsa_if.sv */
`timescale 1ns / 1ps

interface bcsa_in_if;
    import bcsa_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic signed [COORD_W-1:0] row;
    logic signed [COORD_W-1:0] column;
    logic [ELEM_W-1:0]         element;
    logic [INDEX_W-1:0]        index;
    logic [PTR_W-1:0]          pointer;
    logic [VAL_W-1:0]          value;

    modport source (output valid, operation, row, column, element, index, pointer, value,
                    input ready);
    modport sink   (input valid, operation, row, column, element, index, pointer, value,
                    output ready);
endinterface

interface bcsa_out_if;
    import bcsa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    data;

    modport source (output valid, status, data, input ready);
    modport sink   (input valid, status, data, output ready);
endinterface

/* rtl/bcsa_front.sv */
`timescale 1ns / 1ps

module bcsa_front #(
    parameter int MAX_NODES  = bcsa_pkg::MAX_NODES_DEF,
    parameter int MAX_BLOCKS = bcsa_pkg::MAX_BLOCKS_DEF,
    parameter int DOFS       = bcsa_pkg::DOFS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [bcsa_pkg::CFG_W-1:0] i_matrix_size,
    input  bcsa_pkg::t_back_stat       i_back_stat,
    bcsa_in_if.sink                    i_in,
    output logic                       o_push,
    output bcsa_pkg::t_cmd             o_cmd,
    input  logic                       i_queue_ready
);
    import bcsa_pkg::*;

    localparam longint unsigned BLK_SQ    = longint'(DOFS) * longint'(DOFS);
    localparam longint unsigned VAL_DEPTH = longint'(MAX_BLOCKS) * BLK_SQ;
    localparam longint unsigned VEC_DEPTH = longint'(MAX_NODES) * longint'(DOFS);

    logic        r_valid;
    t_cmd        r_cmd;
    t_status     n_status;
    logic        accept;
    logic [31:0] n_eff;
    logic [31:0] row_u;
    logic [31:0] col_u;
    logic [63:0] idx_ext;
    logic [63:0] elem_ext;

    // take a transaction when no reset-time clear sweep runs and the holding register is free or drains this cycle
    assign i_in.ready = !i_back_stat.init_busy && (!r_valid || i_queue_ready);
    assign accept     = i_in.valid && i_in.ready;

    // effective matrix size and widened operands
    assign n_eff    = (32'(i_matrix_size) < 32'(MAX_NODES)) ? 32'(i_matrix_size)
                                                            : 32'(MAX_NODES);
    assign row_u    = 32'(unsigned'(i_in.row));
    assign col_u    = 32'(unsigned'(i_in.column));
    assign idx_ext  = 64'(i_in.index);
    assign elem_ext = 64'(i_in.element);

    // classify: skip, range and table checks
    always_comb begin
        n_status = ST_OK;
        unique case (t_op'(i_in.operation))
            OP_LOAD_ROW: begin
                if (idx_ext > 64'(MAX_NODES)) n_status = ST_BAD_INDEX;
            end
            OP_LOAD_COL: begin
                if (idx_ext >= 64'(MAX_BLOCKS)) n_status = ST_BAD_INDEX;
            end
            OP_CLEAR: begin
                n_status = ST_OK;
            end
            OP_MAT_ADD: begin
                if (i_in.row[COORD_W-1] || i_in.column[COORD_W-1] || (i_in.row > i_in.column))
                    n_status = ST_IGNORED;
                else if ((row_u >= n_eff) || (col_u >= n_eff) || (elem_ext >= BLK_SQ))
                    n_status = ST_RANGE;
            end
            OP_VEC_ADD: begin
                if (i_in.row[COORD_W-1])
                    n_status = ST_IGNORED;
                else if ((row_u >= n_eff) || (elem_ext >= 64'(DOFS)))
                    n_status = ST_RANGE;
            end
            OP_RD_MAT: begin
                if (idx_ext >= VAL_DEPTH) n_status = ST_BAD_INDEX;
            end
            OP_RD_VEC: begin
                if (idx_ext >= VEC_DEPTH) n_status = ST_BAD_INDEX;
            end
            OP_UNUSED: begin
                n_status = ST_IGNORED;
            end
        endcase
    end

    // holding register in front of the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_queue_ready) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_cmd.op      <= t_op'(i_in.operation);
            r_cmd.status  <= n_status;
            r_cmd.row     <= i_in.row[COL_W-1:0];
            r_cmd.col     <= i_in.column[COL_W-1:0];
            r_cmd.elem    <= i_in.element;
            r_cmd.index   <= i_in.index;
            r_cmd.pointer <= i_in.pointer;
            r_cmd.value   <= i_in.value;
        end
    end

    assign o_push = r_valid;
    assign o_cmd  = r_cmd;

endmodule

/* rtl/bcsa_fifo.sv */
`timescale 1ns / 1ps

module bcsa_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bcsa_pkg::t_cmd i_cmd,
    output logic           o_ready,
    output logic           o_valid,
    output bcsa_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import bcsa_pkg::*;

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_ready = (r_count != (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (do_push && !do_pop)      r_count <= r_count + 1'b1;
            else if (!do_push && do_pop) r_count <= r_count - 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wr_ptr] <= i_cmd;
    end

endmodule

/* rtl/bcsa_fpadd.sv */
`timescale 1ns / 1ps

module bcsa_fpadd (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bcsa_pkg::t_fp_req i_req,
    output bcsa_pkg::t_fp_rsp o_rsp
);
    import bcsa_pkg::*;

    localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

    typedef enum logic [2:0] {F_IDLE, F_ALIGN, F_ADD, F_NORM, F_ROUND, F_DONE} t_fstate;

    t_fstate     r_state;
    logic        r_sign_big;
    logic        r_sign_sm;
    logic [11:0] r_exp;
    logic [52:0] r_mbig;
    logic [52:0] r_msm;
    logic [10:0] r_diff;
    logic [55:0] r_al;
    logic [55:0] r_m;
    logic [63:0] r_res;

    logic        a_nan, b_nan, a_inf, b_inf, b_gt;
    logic [63:0] big, sm;
    logic [10:0] e_big, e_sm;
    logic        spec;
    logic [63:0] spec_val;
    logic [55:0] ext, shifted, lost_mask;
    logic        sticky;
    logic [56:0] sum;
    logic        up;
    logic [53:0] rm;
    logic [52:0] mant;
    logic [11:0] e_rnd;
    logic [11:0] e_fld;
    logic [63:0] rnd_val;

    // unpack, order by magnitude, catch NaN and infinity
    always_comb begin
        a_nan = (&i_req.a[62:52]) && (|i_req.a[51:0]);
        b_nan = (&i_req.b[62:52]) && (|i_req.b[51:0]);
        a_inf = (&i_req.a[62:52]) && !(|i_req.a[51:0]);
        b_inf = (&i_req.b[62:52]) && !(|i_req.b[51:0]);
        b_gt  = i_req.b[62:0] > i_req.a[62:0];
        big   = b_gt ? i_req.b : i_req.a;
        sm    = b_gt ? i_req.a : i_req.b;
        e_big = (big[62:52] == '0) ? 11'd1 : big[62:52];
        e_sm  = (sm[62:52] == '0) ? 11'd1 : sm[62:52];
        spec     = 1'b1;
        spec_val = '0;
        priority if (a_nan)                                 spec_val = i_req.a | QUIET_BIT;
        else if (b_nan)                                     spec_val = i_req.b | QUIET_BIT;
        else if (a_inf && b_inf && (i_req.a[63] != i_req.b[63])) spec_val = DEFAULT_NAN;
        else if (a_inf)                                     spec_val = i_req.a;
        else if (b_inf)                                     spec_val = i_req.b;
        else                                                spec     = 1'b0;
    end

    // alignment shift of the smaller operand with sticky collection
    always_comb begin
        ext = {r_msm, 3'b000};
        if (r_diff >= 11'd56) begin
            shifted   = '0;
            lost_mask = '1;
        end else begin
            shifted   = ext >> r_diff;
            lost_mask = (56'd1 << r_diff) - 56'd1;
        end
        sticky = |(ext & lost_mask);
    end

    // magnitude add or subtract
    assign sum = (r_sign_big == r_sign_sm) ? ({1'b0, r_mbig, 3'b000} + {1'b0, r_al})
                                           : ({1'b0, r_mbig, 3'b000} - {1'b0, r_al});

    // round to nearest even and pack
    always_comb begin
        up    = r_m[2] && (r_m[1] || r_m[0] || r_m[3]);
        rm    = {1'b0, r_m[55:3]} + 54'(up);
        if (rm[53]) begin
            mant  = rm[53:1];
            e_rnd = r_exp + 12'd1;
        end else begin
            mant  = rm[52:0];
            e_rnd = r_exp;
        end
        e_fld = mant[52] ? e_rnd : 12'd0;
        if (e_rnd >= 12'd2047) rnd_val = {r_sign_big, 11'h7FF, 52'd0};
        else                   rnd_val = {r_sign_big, e_fld[10:0], mant[51:0]};
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_req.start) begin
                        r_sign_big <= big[63];
                        r_sign_sm  <= sm[63];
                        r_exp      <= {1'b0, e_big};
                        r_mbig     <= {big[62:52] != '0, big[51:0]};
                        r_msm      <= {sm[62:52] != '0, sm[51:0]};
                        r_diff     <= e_big - e_sm;
                        r_res      <= spec_val;
                        r_state    <= spec ? F_DONE : F_ALIGN;
                    end
                end
                F_ALIGN: begin
                    r_al    <= {shifted[55:1], shifted[0] | sticky};
                    r_state <= F_ADD;
                end
                F_ADD: begin
                    if (sum == '0) begin
                        // exact cancellation gives +0, like signs keep theirs
                        r_res   <= {(r_sign_big == r_sign_sm) ? r_sign_big : 1'b0, 63'd0};
                        r_state <= F_DONE;
                    end else if (sum[56]) begin
                        r_m     <= {sum[56:2], sum[1] | sum[0]};
                        r_exp   <= r_exp + 12'd1;
                        r_state <= F_ROUND;
                    end else begin
                        r_m     <= sum[55:0];
                        r_state <= F_NORM;
                    end
                end
                F_NORM: begin
                    // left shift by eight or one until normal or at the subnormal floor
                    if (r_m[55] || (r_exp == 12'd1)) begin
                        r_state <= F_ROUND;
                    end else if ((r_m[55:48] == '0) && (r_exp > 12'd8)) begin
                        r_m   <= {r_m[47:0], 8'd0};
                        r_exp <= r_exp - 12'd8;
                    end else begin
                        r_m   <= {r_m[54:0], 1'b0};
                        r_exp <= r_exp - 12'd1;
                    end
                end
                F_ROUND: begin
                    r_res   <= rnd_val;
                    r_state <= F_DONE;
                end
                F_DONE: begin
                    r_state <= F_IDLE;
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = (r_state == F_DONE);
    assign o_rsp.sum  = r_res;

endmodule

/* rtl/bcsa_back.sv */
`timescale 1ns / 1ps
`include "block_csr_scatter_accumulate_macros.svh"

module bcsa_back #(
    parameter int MAX_NODES  = bcsa_pkg::MAX_NODES_DEF,
    parameter int MAX_BLOCKS = bcsa_pkg::MAX_BLOCKS_DEF,
    parameter int DOFS       = bcsa_pkg::DOFS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  bcsa_pkg::t_cmd       i_cmd,
    output logic                 o_pop,
    output bcsa_pkg::t_back_stat o_stat,
    bcsa_out_if.source           o_out
);
    import bcsa_pkg::*;

    localparam int BLK_SQ    = DOFS * DOFS;
    localparam int VAL_DEPTH = MAX_BLOCKS * BLK_SQ;
    localparam int VEC_DEPTH = MAX_NODES * DOFS;
    localparam int RS_DEPTH  = MAX_NODES + 1;
    localparam int CLR_DEPTH = (VAL_DEPTH > VEC_DEPTH) ? VAL_DEPTH : VEC_DEPTH;
    localparam int RS_AW     = $clog2(RS_DEPTH);
    localparam int COL_AW    = $clog2(MAX_BLOCKS);
    localparam int VAL_AW    = $clog2(VAL_DEPTH);
    localparam int VEC_AW    = $clog2(VEC_DEPTH);
    localparam int CLR_AW    = $clog2(CLR_DEPTH);
    localparam int VAW       = (VAL_AW > VEC_AW) ? VAL_AW : VEC_AW;
    localparam int PW        = $clog2(MAX_BLOCKS + 1);
    localparam int EW        = (PW > PTR_W) ? PW : PTR_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_RS_END, S_SPAN, S_SR_RD, S_SR_CMP,
        S_CHK_RD, S_CHK, S_VAL_RD, S_ADD, S_READ, S_DONE
    } t_state;

    // tables and value stores
    logic [PTR_W-1:0] r_row_start_mem [RS_DEPTH];
    logic [COL_W-1:0] r_col_mem [MAX_BLOCKS];
    logic [VAL_W-1:0] r_val_mem [VAL_DEPTH];
    logic [VAL_W-1:0] r_vec_mem [VEC_DEPTH];

    t_state              r_state;
    t_cmd                r_cmd;
    logic [CLR_AW-1:0]   r_clr;
    logic                r_clr_op;
    logic                r_is_vec;
    logic [PTR_W-1:0]    r_beg;
    logic [PW-1:0]       r_first;
    logic [PW-1:0]       r_count;
    logic [PW-1:0]       r_end;
    logic [VAW-1:0]      r_vaddr;
    t_status             r_res_status;
    logic [VAL_W-1:0]    r_res_data;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [VAL_W-1:0]    r_out_data;
    logic [PTR_W-1:0]    r_rs_rd;
    logic [COL_W-1:0]    r_col_rd;
    logic [VAL_W-1:0]    r_val_rd;
    logic [VAL_W-1:0]    r_vec_rd;

    logic                rs_we;
    logic [RS_AW-1:0]    rs_addr;
    logic                col_we;
    logic [COL_AW-1:0]   col_addr;
    logic                val_we;
    logic [VAL_AW-1:0]   val_raddr;
    logic [VAL_AW-1:0]   val_waddr;
    logic [VAL_W-1:0]    mem_wdata;
    logic                vec_we;
    logic [VEC_AW-1:0]   vec_raddr;
    logic [VEC_AW-1:0]   vec_waddr;

    logic [63:0]         idx_ext;
    logic [31:0]         row_ext;
    logic [31:0]         row_nxt;
    logic [31:0]         vec_off;
    logic [31:0]         blk_off;
    logic [EW-1:0]       span_raw;
    logic [EW-1:0]       span_end;
    logic [EW-1:0]       span_beg;
    logic [PW-1:0]       step;
    logic [PW-1:0]       mid;
    logic [PW-1:0]       n_count;
    logic                out_free;
    logic                clr_last;
    t_fp_req             fp_req;
    t_fp_rsp             fp_rsp;

    // address arithmetic
    assign idx_ext  = 64'(r_cmd.index);
    assign row_ext  = 32'(r_cmd.row);
    assign row_nxt  = row_ext + 32'd1;
    assign vec_off  = row_ext * 32'(DOFS) + 32'(r_cmd.elem);
    assign blk_off  = 32'(r_first) * 32'(BLK_SQ) + 32'(r_cmd.elem);
    assign span_raw = EW'(r_rs_rd);
    assign span_end = (span_raw > EW'(MAX_BLOCKS)) ? EW'(MAX_BLOCKS) : span_raw;
    assign span_beg = EW'(r_beg);
    assign step     = r_count >> 1;
    assign mid      = r_first + step;
    assign n_count  = (r_col_rd < r_cmd.col) ? (r_count - step - PW'(1)) : step;
    assign out_free = !r_out_valid || o_out.ready;
    assign clr_last = (r_clr == CLR_AW'(CLR_DEPTH - 1));
    assign o_pop    = (r_state == S_IDLE) && i_cmd_valid;

    // memory port control
    always_comb begin
        rs_we     = 1'b0;
        rs_addr   = row_ext[RS_AW-1:0];
        col_we    = 1'b0;
        col_addr  = mid[COL_AW-1:0];
        val_we    = 1'b0;
        val_raddr = blk_off[VAL_AW-1:0];
        val_waddr = r_vaddr[VAL_AW-1:0];
        vec_we    = 1'b0;
        vec_raddr = vec_off[VEC_AW-1:0];
        vec_waddr = r_vaddr[VEC_AW-1:0];
        mem_wdata = fp_rsp.sum;
        unique case (r_state)
            S_CLEAR: begin
                val_we    = (r_clr <= CLR_AW'(VAL_DEPTH - 1));
                vec_we    = (r_clr <= CLR_AW'(VEC_DEPTH - 1));
                val_waddr = r_clr[VAL_AW-1:0];
                vec_waddr = r_clr[VEC_AW-1:0];
                mem_wdata = '0;
            end
            S_EXEC: begin
                if (r_cmd.status == ST_OK) begin
                    if (r_cmd.op == OP_LOAD_ROW) begin
                        rs_we   = 1'b1;
                        rs_addr = idx_ext[RS_AW-1:0];
                    end
                    if (r_cmd.op == OP_LOAD_COL) begin
                        col_we   = 1'b1;
                        col_addr = idx_ext[COL_AW-1:0];
                    end
                end
                if (r_cmd.op == OP_RD_MAT) val_raddr = idx_ext[VAL_AW-1:0];
                if (r_cmd.op == OP_RD_VEC) vec_raddr = idx_ext[VEC_AW-1:0];
            end
            S_RS_END: begin
                rs_addr = row_nxt[RS_AW-1:0];
            end
            S_CHK_RD: begin
                col_addr = r_first[COL_AW-1:0];
            end
            S_ADD: begin
                val_we = fp_rsp.done && !r_is_vec;
                vec_we = fp_rsp.done && r_is_vec;
            end
            default: begin
                rs_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rs_we) r_row_start_mem[rs_addr] <= r_cmd.pointer;
        r_rs_rd <= r_row_start_mem[rs_addr];
    end

    always_ff @(posedge i_clk) begin
        if (col_we) r_col_mem[col_addr] <= r_cmd.pointer[COL_W-1:0];
        r_col_rd <= r_col_mem[col_addr];
    end

    always_ff @(posedge i_clk) begin
        if (val_we) r_val_mem[val_waddr] <= mem_wdata;
        r_val_rd <= r_val_mem[val_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (vec_we) r_vec_mem[vec_waddr] <= mem_wdata;
        r_vec_rd <= r_vec_mem[vec_raddr];
    end

    // shared fp64 adder
    assign fp_req.start = (r_state == S_VAL_RD);
    assign fp_req.a     = r_is_vec ? r_vec_rd : r_val_rd;
    assign fp_req.b     = r_cmd.value;

    bcsa_fpadd u_fpadd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fp_req),
        .o_rsp   (fp_rsp)
    );

    // execution sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_clr_op    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && !((r_state == S_DONE) && out_free)) r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= clr_last ? '0 : r_clr + 1'b1;
                    if (clr_last) begin
                        r_res_status <= ST_OK;
                        r_res_data   <= '0;
                        r_state      <= r_clr_op ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res_status <= r_cmd.status;
                    r_res_data   <= '0;
                    r_vaddr      <= VAW'(vec_off);
                    r_is_vec     <= (r_cmd.op == OP_VEC_ADD) || (r_cmd.op == OP_RD_VEC);
                    if (r_cmd.status != ST_OK) begin
                        r_state <= S_DONE;
                    end else begin
                        unique case (r_cmd.op)
                            OP_CLEAR: begin
                                r_clr_op <= 1'b1;
                                r_state  <= S_CLEAR;
                            end
                            OP_MAT_ADD: r_state <= S_RS_END;
                            OP_VEC_ADD: r_state <= S_VAL_RD;
                            OP_RD_MAT:  r_state <= S_READ;
                            OP_RD_VEC:  r_state <= S_READ;
                            default:    r_state <= S_DONE;
                        endcase
                    end
                end
                S_RS_END: begin
                    r_beg   <= r_rs_rd;
                    r_state <= S_SPAN;
                end
                S_SPAN: begin
                    // empty or reversed span
                    if (span_beg >= span_end) begin
                        r_res_status <= ST_NOT_FOUND;
                        r_state      <= S_DONE;
                    end else begin
                        r_first <= PW'(span_beg);
                        r_count <= PW'(span_end - span_beg);
                        r_end   <= PW'(span_end);
                        r_state <= S_SR_RD;
                    end
                end
                S_SR_RD: begin
                    r_state <= S_SR_CMP;
                end
                S_SR_CMP: begin
                    // lower-bound step
                    if (r_col_rd < r_cmd.col) r_first <= mid + PW'(1);
                    r_count <= n_count;
                    r_state <= (n_count == '0) ? S_CHK_RD : S_SR_RD;
                end
                S_CHK_RD: begin
                    if (r_first >= r_end) begin
                        r_res_status <= ST_NOT_FOUND;
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_col_rd != r_cmd.col) begin
                        r_res_status <= ST_NOT_FOUND;
                        r_state      <= S_DONE;
                    end else begin
                        r_vaddr <= VAW'(blk_off);
                        r_state <= S_VAL_RD;
                    end
                end
                S_VAL_RD: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (fp_rsp.done) begin
                        r_res_status <= ST_OK;
                        r_state      <= S_DONE;
                    end
                end
                S_READ: begin
                    r_res_data <= r_is_vec ? r_vec_rd : r_val_rd;
                    r_state    <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_data   <= r_res_data;
                        r_clr_op     <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stat.init_busy = (r_state == S_CLEAR) && !r_clr_op;
    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.data       = r_out_data;

    `BCSA_ASSERT_NOW(a_fp_done_in_add, i_clk, i_rst_n, fp_rsp.done, (r_state == S_ADD), "fp result outside add state")
    `BCSA_ASSERT_NOW(a_no_pop_in_clear, i_clk, i_rst_n, (r_state == S_CLEAR), !o_pop, "queue popped during clear sweep")
    `BCSA_ASSERT_NOW(a_search_in_span, i_clk, i_rst_n, (r_state == S_SR_RD), (({1'b0, r_first} + {1'b0, r_count}) <= {1'b0, r_end}), "search window left row span")
    `BCSA_ASSERT_NEXT(a_done_loads_out, i_clk, i_rst_n, ((r_state == S_DONE) && out_free), (r_out_valid && (r_state == S_IDLE)), "finished result not presented")

endmodule

/* rtl/block_csr_scatter_accumulate.sv */
`timescale 1ns / 1ps
// Block-CSR assembly engine: scatter-add of fp64 values into an upper-triangular
// block matrix and its right-hand vector, plus table loads and word read-back.
// Channels: i_in carries one operation per transaction (valid/ready); o_out returns
// exactly one status/data transaction per accepted operation, in order.
// i_cfg_wr_en / i_cfg_wr_data write matrix_size; write it only while idle.
// From input acceptance to o_out.valid an operation passes the input register, the
// queue, the execution sequencer and the output register. Reads add a store read;
// a vector add adds the fp64 read-add-write (longest on heavy cancellation); a matrix
// add further adds the row-start lookups, a binary search over the row's column span
// and the hit check.
// The execution sequencer takes one operation at a time; the search loop and the
// adder's read-add-write set the rate.
// A clear-values operation sweeps the stores one word per cycle.
// Reset: synchronous, active low. After reset the same clearing sweep runs and
// i_in.ready stays low until it ends; row-start and column tables are not cleared.
// A stalled receiver leaves the result in the output register; a 4-entry queue
// and an input register keep accepting until they fill, then ready drops.
module block_csr_scatter_accumulate #(
    parameter int MAX_NODES  = bcsa_pkg::MAX_NODES_DEF,
    parameter int MAX_BLOCKS = bcsa_pkg::MAX_BLOCKS_DEF,
    parameter int DOFS       = bcsa_pkg::DOFS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [bcsa_pkg::CFG_W-1:0] i_cfg_wr_data,
    bcsa_in_if.sink                    i_in,
    bcsa_out_if.source                 o_out
);
    import bcsa_pkg::*;

    logic [CFG_W-1:0] r_matrix_size;
    t_back_stat       back_stat;
    logic             push;
    t_cmd             push_cmd;
    logic             queue_ready;
    logic             queue_valid;
    t_cmd             queue_cmd;
    logic             pop;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= '0;
        end else if (i_cfg_wr_en) begin
            r_matrix_size <= i_cfg_wr_data;
        end
    end

    bcsa_front #(
        .MAX_NODES  (MAX_NODES),
        .MAX_BLOCKS (MAX_BLOCKS),
        .DOFS       (DOFS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_matrix_size (r_matrix_size),
        .i_back_stat   (back_stat),
        .i_in          (i_in),
        .o_push        (push),
        .o_cmd         (push_cmd),
        .i_queue_ready (queue_ready)
    );

    bcsa_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (queue_ready),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd),
        .i_pop   (pop)
    );

    bcsa_back #(
        .MAX_NODES  (MAX_NODES),
        .MAX_BLOCKS (MAX_BLOCKS),
        .DOFS       (DOFS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_pop       (pop),
        .o_stat      (back_stat),
        .o_out       (o_out)
    );

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
    import bcsa_pkg::*;

    localparam int NODES   = MAX_NODES_DEF;
    localparam int BLOCKS  = MAX_BLOCKS_DEF;
    localparam int DF      = DOFS_DEF;
    localparam int BSQ     = DF * DF;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        t_op                    op;
        logic signed [12:0]     row;
        logic signed [12:0]     col;
        logic [5:0]             elem;
        logic [18:0]            idx;
        logic [15:0]            ptr;
        logic [63:0]            val;
    } t_asm_cmd;

    typedef struct {
        t_status     status;
        logic [63:0] data;
    } t_asm_rsp;

    // assembly scoreboard: mirrors the tables and stores, holds pending responses
    class asm_scoreboard;
        logic [15:0] row_start [int];
        logic [11:0] col_idx [int];
        logic [63:0] blk_val [int];
        logic [63:0] vec_val [int];
        int          size_n;
        t_asm_rsp    pending_rsp [$];
        int          errors;
        int          checked;

        function new();
            size_n  = 0;
            errors  = 0;
            checked = 0;
        endfunction

        function logic [63:0] fp_sum(logic [63:0] a, logic [63:0] b);
            return $realtobits($bitstoreal(a) + $bitstoreal(b));
        endfunction

        function logic [15:0] rs_at(int i);
            return row_start.exists(i) ? row_start[i] : 16'd0;
        endfunction

        function logic [11:0] ci_at(int i);
            return col_idx.exists(i) ? col_idx[i] : 12'd0;
        endfunction

        // true when a matrix add on this row touches only written table entries and its span is at most 64 entries
        function bit search_safe(int r);
            int b;
            int e;
            if (!row_start.exists(r) || !row_start.exists(r + 1)) return 0;
            b = rs_at(r);
            e = rs_at(r + 1);
            if (e > BLOCKS) e = BLOCKS;
            if (b >= e) return 1;
            if (e - b > 64) return 0;
            for (int i = b; i < e; i++)
                if (!col_idx.exists(i)) return 0;
            return 1;
        endfunction

        function void note(t_asm_cmd c);
            t_asm_rsp r;
            int       b;
            int       e;
            int       cnt;
            int       stp;
            int       off;
            r.status = ST_OK;
            r.data   = '0;
            case (c.op)
                OP_LOAD_ROW: begin
                    if (c.idx <= NODES) row_start[int'(c.idx)] = c.ptr;
                    else r.status = ST_BAD_INDEX;
                end
                OP_LOAD_COL: begin
                    if (c.idx < BLOCKS) col_idx[int'(c.idx)] = c.ptr[11:0];
                    else r.status = ST_BAD_INDEX;
                end
                OP_CLEAR: begin
                    blk_val.delete();
                    vec_val.delete();
                end
                OP_MAT_ADD: begin
                    if (c.row < 0 || c.col < 0 || c.row > c.col) begin
                        r.status = ST_IGNORED;
                    end else if (c.row >= size_n || c.col >= size_n || c.elem >= BSQ) begin
                        r.status = ST_RANGE;
                    end else begin
                        b = rs_at(int'(c.row));
                        e = rs_at(int'(c.row) + 1);
                        if (e > BLOCKS) e = BLOCKS;
                        if (b >= e) begin
                            r.status = ST_NOT_FOUND;
                        end else begin
                            // lower bound over the row's column span
                            cnt = e - b;
                            while (cnt > 0) begin
                                stp = cnt / 2;
                                if (int'(ci_at(b + stp)) < int'(c.col)) begin
                                    b   = b + stp + 1;
                                    cnt = cnt - stp - 1;
                                end else begin
                                    cnt = stp;
                                end
                            end
                            if (b >= e || int'(ci_at(b)) != int'(c.col)) begin
                                r.status = ST_NOT_FOUND;
                            end else begin
                                off = b * BSQ + int'(c.elem);
                                blk_val[off] = fp_sum(blk_val.exists(off) ? blk_val[off] : '0,
                                                      c.val);
                            end
                        end
                    end
                end
                OP_VEC_ADD: begin
                    if (c.row < 0) begin
                        r.status = ST_IGNORED;
                    end else if (c.row >= size_n || c.elem >= DF) begin
                        r.status = ST_RANGE;
                    end else begin
                        off = int'(c.row) * DF + int'(c.elem);
                        vec_val[off] = fp_sum(vec_val.exists(off) ? vec_val[off] : '0, c.val);
                    end
                end
                OP_RD_MAT: begin
                    if (c.idx < BLOCKS * BSQ) begin
                        if (blk_val.exists(int'(c.idx))) r.data = blk_val[int'(c.idx)];
                    end else begin
                        r.status = ST_BAD_INDEX;
                    end
                end
                OP_RD_VEC: begin
                    if (c.idx < NODES * DF) begin
                        if (vec_val.exists(int'(c.idx))) r.data = vec_val[int'(c.idx)];
                    end else begin
                        r.status = ST_BAD_INDEX;
                    end
                end
                default: r.status = ST_IGNORED;
            endcase
            pending_rsp = {pending_rsp, r};
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch %0s: got %h want %h (response %0d)", what, got, want, checked);
        endtask

        task check(logic [2:0] status, logic [63:0] data);
            t_asm_rsp w;
            checked++;
            if (pending_rsp.size() == 0) begin
                report("unexpected response", {61'd0, status}, '0);
            end else begin
                w = pending_rsp.pop_front();
                if (status !== w.status) report("status", {61'd0, status}, {61'd0, w.status});
                if (data !== w.data) report("data", data, w.data);
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [CFG_W-1:0] i_cfg_wr_data;

    bcsa_in_if  in_ch ();
    bcsa_out_if out_ch ();

    block_csr_scatter_accumulate dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    asm_scoreboard sb;
    bit no_idle;
    bit hold_req;
    int n_ops [8];

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("block_csr_scatter_accumulate verification failed");
        $finish;
    end

    // response side: check accepted transactions, stall in bursts
    initial begin
        int idle_left;
        int hold_left;
        idle_left = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) sb.check(out_ch.status, out_ch.data);
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 0;
                hold_left = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                out_ch.ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 15) == 0) begin
                idle_left = $urandom_range(1, 19) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    function t_asm_cmd rand_cmd(t_op op);
        t_asm_cmd c;
        c.op   = op;
        c.row  = 13'($urandom);
        c.col  = 13'($urandom);
        c.elem = 6'($urandom);
        c.idx  = 19'($urandom);
        c.ptr  = 16'($urandom);
        c.val  = {$urandom, $urandom};
        return c;
    endfunction

    // finite double near unity, random sign and mantissa
    function logic [63:0] rand_double();
        logic [10:0] ex;
        ex = 11'(1023 - 20 + $urandom_range(0, 40));
        return {1'($urandom), ex, 20'($urandom), $urandom};
    endfunction

    function t_asm_cmd mk(t_op op, int row, int col, int elem, int idx, int ptr,
                          logic [63:0] val);
        t_asm_cmd c;
        c = rand_cmd(op);
        c.row  = 13'(row);
        c.col  = 13'(col);
        c.elem = 6'(elem);
        c.idx  = 19'(idx);
        c.ptr  = 16'(ptr);
        c.val  = val;
        return c;
    endfunction

    // offer one transaction and note it when accepted
    task send(t_asm_cmd c);
        int gap;
        in_ch.valid     <= 1'b1;
        in_ch.operation <= c.op;
        in_ch.row       <= c.row;
        in_ch.column    <= c.col;
        in_ch.element   <= c.elem;
        in_ch.index     <= c.idx;
        in_ch.pointer   <= c.ptr;
        in_ch.value     <= c.val;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note(c);
        n_ops[c.op]++;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task drain();
        in_ch.valid <= 1'b0;
        while (sb.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task write_size(int v);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= CFG_W'(v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.size_n = (v < NODES) ? v : NODES;
    endtask

    // fill low column entries, then pack a random upper-triangular structure
    task build_structure(int n);
        int p;
        for (int i = 0; i < 64; i++) send(mk(OP_LOAD_COL, 0, 0, 0, i, 0, '0));
        p = 0;
        for (int r = 0; r < n; r++) begin
            send(mk(OP_LOAD_ROW, 0, 0, 0, r, p, '0));
            for (int c = r; c < n; c++) begin
                if (c == r || $urandom_range(0, 2) != 0) begin
                    send(mk(OP_LOAD_COL, 0, 0, 0, p, c, '0));
                    p++;
                end
            end
        end
        send(mk(OP_LOAD_ROW, 0, 0, 0, n, p, '0));
    endtask

    function t_asm_cmd random_op();
        t_asm_cmd c;
        int       n;
        int       pick;
        n    = sb.size_n;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            c = rand_cmd(OP_MAT_ADD);
            c.val = rand_double();
            if ($urandom_range(0, 19) == 0) begin
                c.row = 13'($urandom_range(0, n + 1));
                c.col = 13'($urandom);
            end else begin
                c.row  = 13'($urandom_range(0, n > 0 ? n - 1 : 0));
                c.col  = 13'($urandom_range(int'(c.row), n + 1));
                c.elem = 6'($urandom_range(0, BSQ));
            end
            if (!(c.row < 0 || c.col < 0 || c.row > c.col ||
                  c.row >= n || c.col >= n || c.elem >= BSQ) && !sb.search_safe(int'(c.row)))
                c.row = -13'sd1;
        end else if (pick < 70) begin
            c = rand_cmd(OP_VEC_ADD);
            c.val  = rand_double();
            c.row  = 13'($urandom_range(0, n + 1) - ($urandom_range(0, 15) == 0 ? n + 2 : 0));
            c.elem = 6'($urandom_range(0, DF));
        end else if (pick < 78) begin
            c = rand_cmd(OP_RD_MAT);
            if ($urandom_range(0, 4) != 0) c.idx = 19'($urandom_range(0, 40 * BSQ));
        end else if (pick < 86) begin
            c = rand_cmd(OP_RD_VEC);
            if ($urandom_range(0, 4) != 0) c.idx = 19'($urandom_range(0, (n + 1) * DF));
        end else if (pick < 91) begin
            c = rand_cmd(OP_LOAD_ROW);
            c.idx = 19'($urandom_range(0, n));
            c.ptr = 16'($urandom_range(0, 40));
        end else if (pick < 97) begin
            c = rand_cmd(OP_LOAD_COL);
            c.idx = 19'($urandom_range(0, 63));
        end else begin
            c = rand_cmd(OP_UNUSED);
        end
        return c;
    endfunction

    initial begin
        sb = new();
        no_idle  = 0;
        hold_req = 0;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= '0;
        in_ch.row       <= '0;
        in_ch.column    <= '0;
        in_ch.element   <= '0;
        in_ch.index     <= '0;
        in_ch.pointer   <= '0;
        in_ch.value     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // size zero: rejections, table bounds, read bounds
        send(mk(OP_UNUSED, -1, -1, 63, 524287, 65535, '1));
        send(mk(OP_MAT_ADD, -4096, 4095, 0, 0, 0, rand_double()));
        send(mk(OP_MAT_ADD, 5, 3, 0, 0, 0, rand_double()));
        send(mk(OP_MAT_ADD, 0, -1, 0, 0, 0, rand_double()));
        send(mk(OP_MAT_ADD, 0, 0, 0, 0, 0, rand_double()));
        send(mk(OP_VEC_ADD, -1, 0, 0, 0, 0, rand_double()));
        send(mk(OP_VEC_ADD, 0, 0, 0, 0, 0, rand_double()));
        send(mk(OP_LOAD_ROW, 0, 0, 0, NODES + 1, 7, '0));
        send(mk(OP_LOAD_COL, 0, 0, 0, BLOCKS, 7, '0));
        send(mk(OP_LOAD_COL, 0, 0, 0, 524287, 7, '0));
        send(mk(OP_RD_MAT, 0, 0, 0, BLOCKS * BSQ - 1, 0, '0));
        send(mk(OP_RD_MAT, 0, 0, 0, BLOCKS * BSQ, 0, '0));
        send(mk(OP_RD_MAT, 0, 0, 0, 524287, 0, '0));
        send(mk(OP_RD_VEC, 0, 0, 0, NODES * DF - 1, 0, '0));
        send(mk(OP_RD_VEC, 0, 0, 0, NODES * DF, 0, '0));

        // small structure
        write_size(8);
        build_structure(8);
        send(mk(OP_MAT_ADD, 0, 0, BSQ, 0, 0, rand_double()));
        send(mk(OP_MAT_ADD, 0, 0, BSQ - 1, 0, 0, rand_double()));
        send(mk(OP_MAT_ADD, 0, 8, 0, 0, 0, rand_double()));
        send(mk(OP_VEC_ADD, 1, 0, DF, 0, 0, rand_double()));
        send(mk(OP_VEC_ADD, 1, 0, DF - 1, 0, 0, 64'h7FEF_FFFF_FFFF_FFFF));
        send(mk(OP_VEC_ADD, 2, 0, 0, 0, 0, 64'h0000_0000_0000_0001));
        send(mk(OP_RD_VEC, 0, 0, 0, 1 * DF + DF - 1, 0, '0));
        send(mk(OP_RD_VEC, 0, 0, 0, 2 * DF, 0, '0));
        send(mk(OP_LOAD_COL, 0, 0, 0, 63, 65535, '0));

        // back-pressure: response side holds off while commands keep coming
        hold_req = 1;
        for (int i = 0; i < 30; i++) send(random_op());
        drain();
        for (int i = 0; i < 60; i++) send(random_op());

        // largest size: end-of-table row starts
        write_size(NODES);
        send(mk(OP_LOAD_ROW, 0, 0, 0, NODES - 1, BLOCKS, '0));
        send(mk(OP_LOAD_ROW, 0, 0, 0, NODES, BLOCKS, '0));
        send(mk(OP_MAT_ADD, NODES - 1, NODES - 1, 0, 0, 0, rand_double()));
        send(mk(OP_MAT_ADD, 0, NODES - 1, 0, 0, 0, rand_double()));
        send(mk(OP_VEC_ADD, NODES - 1, 0, DF - 1, 0, 0, rand_double()));
        send(mk(OP_RD_VEC, 0, 0, 0, NODES * DF - 1, 0, '0));

        // clear, then confirm the last vector entry reads back zero
        send(mk(OP_CLEAR, 0, 0, 0, 0, 0, '0));
        send(mk(OP_RD_VEC, 0, 0, 0, NODES * DF - 1, 0, '0));

        write_size(3);
        for (int i = 0; i < 70; i++) send(random_op());
        write_size(8);
        for (int i = 0; i < 80; i++) send(random_op());
        no_idle = 1;
        for (int i = 0; i < 60; i++) send(random_op());
        drain();
        write_size(0);

        $display("ran %0d matrix adds, %0d vector adds, %0d reads, %0d loads, %0d clears",
                 n_ops[OP_MAT_ADD], n_ops[OP_VEC_ADD], n_ops[OP_RD_MAT] + n_ops[OP_RD_VEC],
                 n_ops[OP_LOAD_ROW] + n_ops[OP_LOAD_COL], n_ops[OP_CLEAR]);
        $display("sizes 0, 3, 8 and 4096; %0d responses checked, %0d mismatches",
                 sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
            $display("block_csr_scatter_accumulate verification clean");
        end else begin
            $display("block_csr_scatter_accumulate verification failed");
        end
        $finish;
    end

endmodule

/* block_csr_scatter_accumulate.f */
+incdir+rtl
rtl/bcsa_pkg.sv
rtl/bcsa_if.sv
rtl/bcsa_front.sv
rtl/bcsa_fifo.sv
rtl/bcsa_fpadd.sv
rtl/bcsa_back.sv
rtl/block_csr_scatter_accumulate.sv
test/tb.sv
